// ----- design/irl_pkg.sv -----
// ----------------------------------------------------------------------------
// irl_pkg
// Shared constants, types and calibration tables for the IR range linearizer.
// ----------------------------------------------------------------------------
`default_nettype none

package irl_pkg;

  // Field widths
  localparam int ADC_BITS_DEF = 12;
  localparam int CH_W         = 2;
  localparam int DIFF_W       = 13;
  localparam int DIST_W       = 16;
  localparam int THR_W        = 8;
  localparam int CFG_IDX_W    = 4;

  // Output tdata layout: reflect_diff, distance, wall_near, zero pad
  localparam int WALL_BIT     = DIFF_W + DIST_W;
  localparam int OUT_TDATA_W  = ((WALL_BIT + 1 + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - WALL_BIT - 1;

  // Pipeline depth, input stage through output register
  localparam int NUM_STAGES   = 8;

  typedef logic [NUM_STAGES-1:0] stage_vec_t;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRONT_THR = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_THR  = CFG_IDX_W'(1);

  localparam logic [THR_W-1:0] FRONT_THR_RST = THR_W'(80);
  localparam logic [THR_W-1:0] SIDE_THR_RST  = THR_W'(40);

  // Distance offsets
  localparam int FRONT_OFFSET = 60;
  localparam int SIDE_OFFSET  = 20;

  // Coefficient magnitudes, Q48, widths cover the largest channel
  localparam int FRAC_BITS = 48;
  localparam int C3W       = 29;
  localparam int C2W       = 39;
  localparam int C2LW      = 20;
  localparam int C1W       = 48;
  localparam int C0W       = 56;

  localparam logic [63:0] Q_C3_0 = ((64'd1026 << 48) + 64'd100000000000 / 64'd2)
                                   / 64'd100000000000;
  localparam logic [63:0] Q_C2_0 = ((64'd717 << 48) + 64'd10000000 / 64'd2) / 64'd10000000;
  localparam logic [63:0] Q_C1_0 = ((64'd159 << 48) + 64'd1000 / 64'd2) / 64'd1000;
  localparam logic [63:0] Q_C0_0 = ((64'd18717 << 48) + 64'd100 / 64'd2) / 64'd100;

  localparam logic [63:0] Q_C3_1 = ((64'd1125 << 48) + 64'd1000000000 / 64'd2)
                                   / 64'd1000000000;
  localparam logic [63:0] Q_C2_1 = ((64'd145 << 48) + 64'd100000 / 64'd2) / 64'd100000;
  localparam logic [63:0] Q_C1_1 = ((64'd623 << 48) + 64'd1000 / 64'd2) / 64'd1000;
  localparam logic [63:0] Q_C0_1 = 64'd114 << 48;

  localparam logic [63:0] Q_C3_2 = ((64'd929 << 48) + 64'd100000000000 / 64'd2)
                                   / 64'd100000000000;
  localparam logic [63:0] Q_C2_2 = ((64'd642 << 48) + 64'd10000000 / 64'd2) / 64'd10000000;
  localparam logic [63:0] Q_C1_2 = ((64'd14 << 48) + 64'd100 / 64'd2) / 64'd100;
  localparam logic [63:0] Q_C0_2 = ((64'd1698 << 48) + 64'd10 / 64'd2) / 64'd10;

  localparam logic [63:0] Q_C3_3 = ((64'd228 << 48) + 64'd1000000000 / 64'd2)
                                   / 64'd1000000000;
  localparam logic [63:0] Q_C2_3 = ((64'd479 << 48) + 64'd1000000 / 64'd2) / 64'd1000000;
  localparam logic [63:0] Q_C1_3 = ((64'd337 << 48) + 64'd1000 / 64'd2) / 64'd1000;
  localparam logic [63:0] Q_C0_3 = ((64'd1039 << 48) + 64'd10 / 64'd2) / 64'd10;

  function automatic logic [C3W-1:0] coef_c3(input logic [CH_W-1:0] ch);
    logic [C3W-1:0] c;
    case (ch)
      2'd0:    c = Q_C3_0[C3W-1:0];
      2'd1:    c = Q_C3_1[C3W-1:0];
      2'd2:    c = Q_C3_2[C3W-1:0];
      default: c = Q_C3_3[C3W-1:0];
    endcase
    return c;
  endfunction

  function automatic logic [C2W-1:0] coef_c2(input logic [CH_W-1:0] ch);
    logic [C2W-1:0] c;
    case (ch)
      2'd0:    c = Q_C2_0[C2W-1:0];
      2'd1:    c = Q_C2_1[C2W-1:0];
      2'd2:    c = Q_C2_2[C2W-1:0];
      default: c = Q_C2_3[C2W-1:0];
    endcase
    return c;
  endfunction

  function automatic logic [C1W-1:0] coef_c1(input logic [CH_W-1:0] ch);
    logic [C1W-1:0] c;
    case (ch)
      2'd0:    c = Q_C1_0[C1W-1:0];
      2'd1:    c = Q_C1_1[C1W-1:0];
      2'd2:    c = Q_C1_2[C1W-1:0];
      default: c = Q_C1_3[C1W-1:0];
    endcase
    return c;
  endfunction

  function automatic logic [C0W-1:0] coef_c0(input logic [CH_W-1:0] ch);
    logic [C0W-1:0] c;
    case (ch)
      2'd0:    c = Q_C0_0[C0W-1:0];
      2'd1:    c = Q_C0_1[C0W-1:0];
      2'd2:    c = Q_C0_2[C0W-1:0];
      default: c = Q_C0_3[C0W-1:0];
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/irl_poly.sv -----
// ----------------------------------------------------------------------------
// irl_poly
// Stages one to six: difference, powers, coefficient products, exact Q48 sum.
// ----------------------------------------------------------------------------
`default_nettype none

module irl_poly #(
  parameter int ADC_BITS = irl_pkg::ADC_BITS_DEF,
  parameter int SUM_W    = 80
) (
  input  wire logic                         clk_i,
  input  wire irl_pkg::stage_vec_t          en_i,
  input  wire logic [irl_pkg::CH_W-1:0]     ch_i,
  input  wire logic [ADC_BITS-1:0]          ambient_i,
  input  wire logic [ADC_BITS-1:0]          lit_i,
  output logic      [irl_pkg::CH_W-1:0]     ch_o,
  output logic signed [ADC_BITS:0]          x_o,
  output logic signed [SUM_W-1:0]           sum_o
);
  import irl_pkg::*;

  localparam int MW    = ADC_BITS;
  localparam int AW    = ADC_BITS + 1;
  localparam int AX2W  = 2 * MW;
  localparam int AX3W  = 3 * MW;
  localparam int A3LW  = AX3W / 2;
  localparam int A3HW  = AX3W - A3LW;
  localparam int C2HW  = C2W - C2LW;
  localparam int P2HW  = C2HW + AX2W;
  localparam int P2LW  = C2LW + AX2W;
  localparam int T2W   = C2W + AX2W;
  localparam int P1W   = C1W + MW;
  localparam int P3HW  = C3W + A3HW;
  localparam int P3LW  = C3W + A3LW;
  localparam int T3W   = C3W + AX3W;

  // Stage 1: difference and magnitude
  logic signed [AW-1:0] x_d, nx;
  logic [MW-1:0]        ax_d;
  logic [CH_W-1:0]      s1_ch_q;
  logic signed [AW-1:0] s1_x_q;
  logic [MW-1:0]        s1_ax_q;

  always_comb begin
    x_d  = $signed({1'b0, lit_i}) - $signed({1'b0, ambient_i});
    nx   = -x_d;
    ax_d = x_d[AW-1] ? nx[MW-1:0] : x_d[MW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s1_ch_q <= ch_i;
      s1_x_q  <= x_d;
      s1_ax_q <= ax_d;
    end
  end

  // Stage 2: square
  logic [CH_W-1:0]      s2_ch_q;
  logic signed [AW-1:0] s2_x_q;
  logic [MW-1:0]        s2_ax_q;
  logic [AX2W-1:0]      s2_ax2_q;

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s2_ch_q  <= s1_ch_q;
      s2_x_q   <= s1_x_q;
      s2_ax_q  <= s1_ax_q;
      s2_ax2_q <= AX2W'(s1_ax_q) * AX2W'(s1_ax_q);
    end
  end

  // Stage 3: cube, square and linear products
  logic [C2W-1:0]       c2_s3;
  logic [C1W-1:0]       c1_s3;
  logic [CH_W-1:0]      s3_ch_q;
  logic signed [AW-1:0] s3_x_q;
  logic [AX3W-1:0]      s3_ax3_q;
  logic [P2HW-1:0]      s3_p2h_q;
  logic [P2LW-1:0]      s3_p2l_q;
  logic [P1W-1:0]       s3_p1_q;

  always_comb begin
    c2_s3 = coef_c2(s2_ch_q);
    c1_s3 = coef_c1(s2_ch_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      s3_ch_q  <= s2_ch_q;
      s3_x_q   <= s2_x_q;
      s3_ax3_q <= AX3W'(s2_ax2_q) * AX3W'(s2_ax_q);
      s3_p2h_q <= P2HW'(c2_s3[C2W-1:C2LW]) * P2HW'(s2_ax2_q);
      s3_p2l_q <= P2LW'(c2_s3[C2LW-1:0]) * P2LW'(s2_ax2_q);
      s3_p1_q  <= P1W'(c1_s3) * P1W'(s2_ax_q);
    end
  end

  // Stage 4: cubic partial products, merge square term
  logic [C3W-1:0]       c3_s4;
  logic [CH_W-1:0]      s4_ch_q;
  logic signed [AW-1:0] s4_x_q;
  logic [P3HW-1:0]      s4_p3h_q;
  logic [P3LW-1:0]      s4_p3l_q;
  logic [T2W-1:0]       s4_t2_q;
  logic [P1W-1:0]       s4_p1_q;

  assign c3_s4 = coef_c3(s3_ch_q);

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      s4_ch_q  <= s3_ch_q;
      s4_x_q   <= s3_x_q;
      s4_p3h_q <= P3HW'(c3_s4) * P3HW'(s3_ax3_q[AX3W-1:A3LW]);
      s4_p3l_q <= P3LW'(c3_s4) * P3LW'(s3_ax3_q[A3LW-1:0]);
      s4_t2_q  <= (T2W'(s3_p2h_q) << C2LW) + T2W'(s3_p2l_q);
      s4_p1_q  <= s3_p1_q;
    end
  end

  // Stage 5: merge cubic term; constant + square - linear (sign follows x)
  logic signed [SUM_W-1:0] c0s, t2s, p1s, t12_d;
  logic [CH_W-1:0]         s5_ch_q;
  logic signed [AW-1:0]    s5_x_q;
  logic [T3W-1:0]          s5_t3_q;
  logic signed [SUM_W-1:0] s5_t12_q;

  always_comb begin
    c0s   = $signed(SUM_W'(coef_c0(s4_ch_q)));
    t2s   = $signed(SUM_W'(s4_t2_q));
    p1s   = $signed(SUM_W'(s4_p1_q));
    t12_d = c0s + t2s + (s4_x_q[AW-1] ? p1s : -p1s);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      s5_ch_q  <= s4_ch_q;
      s5_x_q   <= s4_x_q;
      s5_t3_q  <= (T3W'(s4_p3h_q) << A3LW) + T3W'(s4_p3l_q);
      s5_t12_q <= t12_d;
    end
  end

  // Stage 6: subtract the cubic term
  logic signed [SUM_W-1:0] t3s, sum_d;
  logic [CH_W-1:0]         s6_ch_q;
  logic signed [AW-1:0]    s6_x_q;
  logic signed [SUM_W-1:0] s6_sum_q;

  always_comb begin
    t3s   = $signed(SUM_W'(s5_t3_q));
    sum_d = s5_t12_q + (s5_x_q[AW-1] ? t3s : -t3s);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      s6_ch_q  <= s5_ch_q;
      s6_x_q   <= s5_x_q;
      s6_sum_q <= sum_d;
    end
  end

  assign ch_o  = s6_ch_q;
  assign x_o   = s6_x_q;
  assign sum_o = s6_sum_q;

endmodule

`default_nettype wire

// ----- design/irl_finish.sv -----
// ----------------------------------------------------------------------------
// irl_finish
// Stages seven and eight: truncate toward zero, offset, saturate, compare.
// ----------------------------------------------------------------------------
`default_nettype none

module irl_finish #(
  parameter int ADC_BITS = irl_pkg::ADC_BITS_DEF,
  parameter int SUM_W    = 80
) (
  input  wire logic                          clk_i,
  input  wire irl_pkg::stage_vec_t           en_i,
  input  wire logic [irl_pkg::CH_W-1:0]      ch_i,
  input  wire logic signed [ADC_BITS:0]      x_i,
  input  wire logic signed [SUM_W-1:0]       sum_i,
  input  wire logic [irl_pkg::THR_W-1:0]     front_thr_i,
  input  wire logic [irl_pkg::THR_W-1:0]     side_thr_i,
  output logic      [irl_pkg::CH_W-1:0]      ch_o,
  output logic      [irl_pkg::DIFF_W-1:0]    diff_o,
  output logic      [irl_pkg::DIST_W-1:0]    dist_o,
  output logic                               wall_o
);
  import irl_pkg::*;

  localparam int AW  = ADC_BITS + 1;
  localparam int HW  = SUM_W - FRAC_BITS;
  localparam int QW  = HW + 1;
  localparam int DW  = ((QW > DIST_W) ? QW : DIST_W) + 2;
  localparam int XEW = (AW > DIFF_W) ? AW : DIFF_W;

  localparam logic signed [DW-1:0] DMAX      = DW'((2 ** (DIST_W - 1)) - 1);
  localparam logic signed [DW-1:0] DMIN      = -DMAX - DW'(1);
  localparam logic signed [DW-1:0] FRONT_OFF = DW'(FRONT_OFFSET);
  localparam logic signed [DW-1:0] SIDE_OFF  = DW'(SIDE_OFFSET);

  // Stage 7: integer part, rounded toward zero
  logic signed [HW-1:0]  hi;
  logic                  corr;
  logic signed [QW-1:0]  quot_d;
  logic [CH_W-1:0]       s7_ch_q;
  logic signed [AW-1:0]  s7_x_q;
  logic signed [QW-1:0]  s7_quot_q;

  always_comb begin
    hi     = sum_i[SUM_W-1:FRAC_BITS];
    corr   = sum_i[SUM_W-1] && (sum_i[FRAC_BITS-1:0] != '0);
    quot_d = QW'(hi) + QW'(corr);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      s7_ch_q   <= ch_i;
      s7_x_q    <= x_i;
      s7_quot_q <= quot_d;
    end
  end

  // Stage 8: offset, saturate, threshold compare
  logic                  front;
  logic signed [DW-1:0]  dw, sat, thr_s;
  logic signed [XEW-1:0] xe;
  logic [CH_W-1:0]       s8_ch_q;
  logic [DIFF_W-1:0]     s8_diff_q;
  logic [DIST_W-1:0]     s8_dist_q;
  logic                  s8_wall_q;

  always_comb begin
    front = !s7_ch_q[0];
    dw    = DW'(s7_quot_q) - (front ? FRONT_OFF : SIDE_OFF);
    if (dw > DMAX) begin
      sat = DMAX;
    end else if (dw < DMIN) begin
      sat = DMIN;
    end else begin
      sat = dw;
    end
    // Threshold is non-negative, so compare before saturation.
    thr_s = $signed(DW'(front ? front_thr_i : side_thr_i));
    xe    = XEW'(s7_x_q);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[7]) begin
      s8_ch_q   <= s7_ch_q;
      s8_diff_q <= xe[DIFF_W-1:0];
      s8_dist_q <= sat[DIST_W-1:0];
      s8_wall_q <= (dw <= thr_s);
    end
  end

  assign ch_o   = s8_ch_q;
  assign diff_o = s8_diff_q;
  assign dist_o = s8_dist_q;
  assign wall_o = s8_wall_q;

endmodule

`default_nettype wire

// ----- design/ir_range_linearizer_top.sv -----
// ----------------------------------------------------------------------------
// ir_range_linearizer_top
// Calibrated IR wall distance from one ambient/lit sample pair per transaction.
// ----------------------------------------------------------------------------
// Each input transaction carries a channel (tuser) and the ambient and lit ADC
// readings (tdata). The block forms lit minus ambient, evaluates the channel's
// cubic calibration polynomial exactly in Q48 fixed point, truncates toward
// zero, subtracts the front or side offset, saturates to 16 bits and flags a
// near wall against the channel's threshold. It takes one transaction per
// clock while s_axis_tready is high. The first of the eight register stages
// of the multiply/add pipeline loads at the accepting edge, and a result is
// presented on m_axis once it reaches the last stage (square, cube
// and coefficient products are split so no multiplier exceeds about 32x32
// bits). Each stage advances on its own when the stage ahead is empty or
// moving, so bubbles are squeezed out and input keeps flowing while a
// finished result waits on m_axis_tready, until all eight stages hold a
// transaction; then s_axis_tready drops until the result leaves. Thresholds
// are written through the cfg port (index 0 front, 1 side; other indexes are
// dropped) and must only be changed while no transaction is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_range_linearizer_top #(
  parameter  int ADC_BITS   = irl_pkg::ADC_BITS_DEF,
  localparam int IN_TDATA_W = ((2 * ADC_BITS + 7) / 8) * 8
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // Sample stream
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [ADC_BITS-1:0] ambient_level, [2*ADC_BITS-1:ADC_BITS] lit_level, zero pad
  input  wire logic [IN_TDATA_W-1:0]             s_axis_tdata,
  // [1:0] channel
  input  wire logic [irl_pkg::CH_W-1:0]          s_axis_tuser,
  // Result stream
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [12:0] reflect_diff, [28:13] distance, [29] wall_near, zero pad
  output logic [irl_pkg::OUT_TDATA_W-1:0]        m_axis_tdata,
  // [1:0] channel_out
  output logic [irl_pkg::CH_W-1:0]               m_axis_tuser,
  // Configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [irl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [irl_pkg::THR_W-1:0]         cfg_data_i
);
  import irl_pkg::*;

  // Exact sum width: widest term plus sign and carry headroom
  localparam int T3W    = C3W + 3 * ADC_BITS;
  localparam int T2W    = C2W + 2 * ADC_BITS;
  localparam int P1W    = C1W + ADC_BITS;
  localparam int MAX_A  = (T3W > T2W) ? T3W : T2W;
  localparam int MAX_B  = (MAX_A > P1W) ? MAX_A : P1W;
  localparam int MAX_C  = (MAX_B > C0W) ? MAX_B : C0W;
  localparam int SUM_W  = MAX_C + 3;

  // --------------------------------------------------------------------------
  // Threshold registers
  // --------------------------------------------------------------------------
  logic [THR_W-1:0] front_thr_q, front_thr_d;
  logic [THR_W-1:0] side_thr_q, side_thr_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    front_thr_d = front_thr_q;
    side_thr_d  = side_thr_q;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_FRONT_THR: front_thr_d = cfg_data_i;
        CFG_SIDE_THR:  side_thr_d  = cfg_data_i;
        default: ; // unmapped index: drop the write
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_thr_q <= FRONT_THR_RST;
      side_thr_q  <= SIDE_THR_RST;
    end else begin
      front_thr_q <= front_thr_d;
      side_thr_q  <= side_thr_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage valid bits and per-stage advance
  // A stage loads when it is empty or its content moves on this cycle.
  // --------------------------------------------------------------------------
  stage_vec_t valid_q, valid_d, en;

  always_comb begin
    en[NUM_STAGES-1] = !valid_q[NUM_STAGES-1] || m_axis_tready;
    for (int k = NUM_STAGES - 2; k >= 0; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  // Hold each valid bit unless its stage advances; then take the one behind.
  assign valid_d = (en & {valid_q[NUM_STAGES-2:0], s_axis_tvalid}) | (~en & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign s_axis_tready = en[0];
  assign m_axis_tvalid = valid_q[NUM_STAGES-1];

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  logic [CH_W-1:0]          poly_ch;
  logic signed [ADC_BITS:0] poly_x;
  logic signed [SUM_W-1:0]  poly_sum;
  logic [CH_W-1:0]          res_ch;
  logic [DIFF_W-1:0]        res_diff;
  logic [DIST_W-1:0]        res_dist;
  logic                     res_wall;

  irl_poly #(
    .ADC_BITS (ADC_BITS),
    .SUM_W    (SUM_W)
  ) u_poly (
    .clk_i     (clk_i),
    .en_i      (en),
    .ch_i      (s_axis_tuser),
    .ambient_i (s_axis_tdata[ADC_BITS-1:0]),
    .lit_i     (s_axis_tdata[2*ADC_BITS-1:ADC_BITS]),
    .ch_o      (poly_ch),
    .x_o       (poly_x),
    .sum_o     (poly_sum)
  );

  irl_finish #(
    .ADC_BITS (ADC_BITS),
    .SUM_W    (SUM_W)
  ) u_finish (
    .clk_i       (clk_i),
    .en_i        (en),
    .ch_i        (poly_ch),
    .x_i         (poly_x),
    .sum_i       (poly_sum),
    .front_thr_i (front_thr_q),
    .side_thr_i  (side_thr_q),
    .ch_o        (res_ch),
    .diff_o      (res_diff),
    .dist_o      (res_dist),
    .wall_o      (res_wall)
  );

  assign m_axis_tdata = {{OUT_PAD_W{1'b0}}, res_wall, res_dist, res_diff};
  assign m_axis_tuser = res_ch;

endmodule

`default_nettype wire

// ----- design/irl_checker.sv -----
// ----------------------------------------------------------------------------
// irl_checker
// Port-level assertions for the IR range linearizer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module irl_checker #(
  parameter  int ADC_BITS   = irl_pkg::ADC_BITS_DEF,
  localparam int IN_TDATA_W = ((2 * ADC_BITS + 7) / 8) * 8
) (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid,
  input wire logic                              s_axis_tready,
  input wire logic [IN_TDATA_W-1:0]             s_axis_tdata,
  input wire logic [irl_pkg::CH_W-1:0]          s_axis_tuser,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [irl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  input wire logic [irl_pkg::CH_W-1:0]          m_axis_tuser,
  input wire logic                              cfg_valid_i,
  input wire logic                              cfg_ready_o,
  input wire logic [irl_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input wire logic [irl_pkg::THR_W-1:0]         cfg_data_i
);
  import irl_pkg::*;

  localparam int CNT_W = $clog2(NUM_STAGES + 1);

  logic                     in_acc, out_acc;
  logic [CNT_W-1:0]         pending_q, pending_d;
  logic [THR_W-1:0]         front_thr_q, side_thr_q;
  logic signed [DIST_W-1:0] dist_val;
  logic signed [THR_W:0]    thr_s;
  logic                     wall;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  always_comb begin
    pending_d = pending_q;
    if (in_acc && !out_acc) begin
      pending_d = pending_q + CNT_W'(1);
    end else if (!in_acc && out_acc) begin
      pending_d = pending_q - CNT_W'(1);
    end
  end

  // Shadow the thresholds from the write port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q   <= '0;
      front_thr_q <= FRONT_THR_RST;
      side_thr_q  <= SIDE_THR_RST;
    end else begin
      pending_q <= pending_d;
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_FRONT_THR)) begin
        front_thr_q <= cfg_data_i;
      end
      if (cfg_valid_i && cfg_ready_o && (cfg_index_i == CFG_SIDE_THR)) begin
        side_thr_q <= cfg_data_i;
      end
    end
  end

  assign dist_val = m_axis_tdata[WALL_BIT-1:DIFF_W];
  assign wall     = m_axis_tdata[WALL_BIT];
  assign thr_s    = {1'b0, (m_axis_tuser[0] ? side_thr_q : front_thr_q)};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  a_wall_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (wall == (dist_val <= thr_s)))
    else $error("wall_near disagrees with distance and threshold");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (pending_q != '0))
    else $error("result presented with no sample in flight");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CNT_W'(NUM_STAGES))
    else $error("more samples in flight than pipeline stages");

endmodule

bind ir_range_linearizer_top irl_checker #(.ADC_BITS(ADC_BITS)) u_irl_checker (.*);

`default_nettype wire

// ----- sim/tb_ir_range_linearizer_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ir_range_linearizer_top
// Self-checking bench for the IR range linearizer.
// ----------------------------------------------------------------------------
// Sends channel samples in as stream transactions and checks every result
// transaction in order. The expected distance comes from an exact 128-bit
// evaluation of each channel's cubic calibration curve. A short table of
// directed samples runs first, at the reset thresholds. Several threshold
// settings follow, each with a block of random samples. Both stream sides
// pause at random, and one long output hold-off backs up the pipeline.
// ----------------------------------------------------------------------------

module tb_ir_range_linearizer_top;

  import irl_pkg::*;

  localparam int ADC_W      = ADC_BITS_DEF;
  localparam int IN_TDATA_W = ((2 * ADC_W + 7) / 8) * 8;
  localparam int ADC_MAX    = (1 << ADC_W) - 1;

  // Threshold values right after reset
  localparam logic [THR_W-1:0] FRONT_LIMIT_RST = 8'd80;
  localparam logic [THR_W-1:0] SIDE_LIMIT_RST  = 8'd40;

  localparam int FRONT_DROP = 60;
  localparam int SIDE_DROP  = 20;

  localparam int RANDOM_PHASES    = 5;
  localparam int SAMPLES_PER_PHASE = 200;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int SETTLE_LIMIT     = 20000;
  localparam int MAX_REPORTS      = 100;

  localparam logic signed [127:0] Q48_UNIT = 128'sd1 <<< 48;

  // One result transaction, fields in the order they sit on the bus
  typedef struct packed {
    logic [CH_W-1:0]   ch;
    logic [DIFF_W-1:0] diff;
    logic [DIST_W-1:0] distance;
    logic              near;
  } range_result_t;

  // One directed sample; the result is typed in only where 'typed' is set
  typedef struct packed {
    logic [CH_W-1:0]  ch;
    logic [ADC_W-1:0] ambient;
    logic [ADC_W-1:0] lit;
    logic             typed;
    range_result_t    res;
  } sample_row_t;

  localparam int NUM_ROWS = 23;

  localparam sample_row_t DIRECTED_ROWS [NUM_ROWS] = '{
    // zero difference: constant term minus offset
    '{2'd0, 12'd0,    12'd0,    1'b1, '{2'd0, 13'd0,     16'd127,   1'b0}},
    '{2'd1, 12'd0,    12'd0,    1'b1, '{2'd1, 13'd0,     16'd94,    1'b0}},
    '{2'd2, 12'd0,    12'd0,    1'b1, '{2'd2, 13'd0,     16'd109,   1'b0}},
    '{2'd3, 12'd0,    12'd0,    1'b1, '{2'd3, 13'd0,     16'd83,    1'b0}},
    '{2'd0, 12'd4095, 12'd4095, 1'b1, '{2'd0, 13'd0,     16'd127,   1'b0}},
    '{2'd3, 12'd4095, 12'd4095, 1'b1, '{2'd3, 13'd0,     16'd83,    1'b0}},
    // full-scale difference on the steepest side curve: saturate both ways
    '{2'd1, 12'd0,    12'd4095, 1'b1, '{2'd1, 13'h0FFF,  16'h8000,  1'b1}},
    '{2'd1, 12'd4095, 12'd0,    1'b1, '{2'd1, 13'h1001,  16'h7FFF,  1'b0}},
    '{2'd0, 12'd0,    12'd4095, 1'b0, '0},
    '{2'd0, 12'd4095, 12'd0,    1'b0, '0},
    '{2'd2, 12'd0,    12'd4095, 1'b0, '0},
    '{2'd2, 12'd4095, 12'd0,    1'b0, '0},
    '{2'd3, 12'd0,    12'd4095, 1'b0, '0},
    '{2'd3, 12'd4095, 12'd0,    1'b0, '0},
    // unit steps around zero
    '{2'd0, 12'd100,  12'd101,  1'b0, '0},
    '{2'd1, 12'd101,  12'd100,  1'b0, '0},
    // negative and positive mid-range differences
    '{2'd2, 12'd2000, 12'd1000, 1'b0, '0},
    '{2'd3, 12'd1000, 12'd2000, 1'b0, '0},
    '{2'd0, 12'hAAA,  12'h555,  1'b0, '0},
    '{2'd1, 12'h555,  12'hAAA,  1'b0, '0},
    '{2'd2, 12'h555,  12'hAAA,  1'b0, '0},
    '{2'd3, 12'hAAA,  12'h555,  1'b0, '0},
    '{2'd1, 12'd3000, 12'd3400, 1'b0, '0}
  };

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                    s_axis_tvalid = 1'b0;
  logic                    s_axis_tready;
  logic [IN_TDATA_W-1:0]   s_axis_tdata  = '0;
  logic [CH_W-1:0]         s_axis_tuser  = '0;
  logic                    m_axis_tvalid;
  logic                    m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0]  m_axis_tdata;
  logic [CH_W-1:0]         m_axis_tuser;
  logic                    cfg_valid_i   = 1'b0;
  logic                    cfg_ready_o;
  logic [CFG_IDX_W-1:0]    cfg_index_i   = '0;
  logic [THR_W-1:0]        cfg_data_i    = '0;

  // Thresholds as the block should hold them
  logic [THR_W-1:0] front_limit = FRONT_LIMIT_RST;
  logic [THR_W-1:0] side_limit  = SIDE_LIMIT_RST;

  range_result_t expected_ranges[$];

  bit quiet_run    = 1'b0;  // no pauses on either side
  bit hold_request = 1'b0;  // ask the receiver for one long hold-off

  int errors         = 0;
  int reports        = 0;
  int samples_sent   = 0;
  int results_seen   = 0;
  int saturated_seen = 0;
  int near_seen      = 0;
  int negative_seen  = 0;
  int settings_run   = 0;

  ir_range_linearizer_top DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Calibration coefficient magnitude in Q48, rounded to nearest.
  // Term order: 3 cubic, 2 square, 1 linear, 0 constant.
  function automatic logic [63:0] calib_q48(input logic [CH_W-1:0] ch, input int term);
    logic [63:0] num;
    logic [63:0] den;
    case ({ch, 2'(term)})
      4'h3: begin num = 64'd1026;  den = 64'd100000000000; end
      4'h2: begin num = 64'd717;   den = 64'd10000000;     end
      4'h1: begin num = 64'd159;   den = 64'd1000;         end
      4'h0: begin num = 64'd18717; den = 64'd100;          end
      4'h7: begin num = 64'd1125;  den = 64'd1000000000;   end
      4'h6: begin num = 64'd145;   den = 64'd100000;       end
      4'h5: begin num = 64'd623;   den = 64'd1000;         end
      4'h4: begin num = 64'd114;   den = 64'd1;            end
      4'hB: begin num = 64'd929;   den = 64'd100000000000; end
      4'hA: begin num = 64'd642;   den = 64'd10000000;     end
      4'h9: begin num = 64'd14;    den = 64'd100;          end
      4'h8: begin num = 64'd1698;  den = 64'd10;           end
      4'hF: begin num = 64'd228;   den = 64'd1000000000;   end
      4'hE: begin num = 64'd479;   den = 64'd1000000;      end
      4'hD: begin num = 64'd337;   den = 64'd1000;         end
      default: begin num = 64'd1039; den = 64'd10;         end
    endcase
    return ((num << 48) + den / 2) / den;
  endfunction

  // Distance for one sample: exact curve, truncate toward zero, offset,
  // saturate to 16 bits, then compare with the channel's threshold.
  function automatic range_result_t calc_range(input logic [CH_W-1:0] ch,
                                               input logic [ADC_W-1:0] ambient,
                                               input logic [ADC_W-1:0] lit);
    range_result_t      r;
    logic signed [127:0] x;
    logic signed [127:0] c3, c2, c1, c0;
    logic signed [127:0] acc;
    logic signed [127:0] dist_val;
    logic [THR_W-1:0]    limit;
    bit                  front;
    front = (ch[0] == 1'b0);
    x  = int'(lit) - int'(ambient);
    c3 = {64'd0, calib_q48(ch, 3)};
    c2 = {64'd0, calib_q48(ch, 2)};
    c1 = {64'd0, calib_q48(ch, 1)};
    c0 = {64'd0, calib_q48(ch, 0)};
    acc  = -(c3 * x * x * x) + c2 * x * x - c1 * x + c0;
    dist_val = acc / Q48_UNIT - (front ? FRONT_DROP : SIDE_DROP);
    if (dist_val > 32767) dist_val = 32767;
    if (dist_val < -32768) dist_val = -32768;
    limit  = front ? front_limit : side_limit;
    r.ch   = ch;
    r.diff = x[DIFF_W-1:0];
    r.distance = dist_val[DIST_W-1:0];
    r.near = (dist_val <= $signed({1'b0, limit}));
    return r;
  endfunction

  // Offer one sample, hold it until accepted, then maybe pause the input.
  task automatic offer_sample(input logic [CH_W-1:0] ch, input logic [ADC_W-1:0] ambient,
                              input logic [ADC_W-1:0] lit, input bit typed,
                              input range_result_t typed_res);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_TDATA_W'({lit, ambient});
    s_axis_tuser  <= ch;
    do @(posedge clk_i); while (!s_axis_tready);
    expected_ranges.push_back(typed ? typed_res : calc_range(ch, ambient, lit));
    samples_sent++;
    if (!quiet_run && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
  endtask

  // Write one threshold register; the caller drops cfg_valid_i after its batch.
  task automatic write_limit(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CFG_FRONT_THR) begin
      front_limit = value;
    end else if (idx == CFG_SIDE_THR) begin
      side_limit = value;
    end
  endtask

  // Wait for every outstanding result, then let the pipeline settle.
  task automatic wait_for_results(input int limit);
    int waited;
    waited = 0;
    while (expected_ranges.size() != 0 && waited < limit) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (2 * NUM_STAGES) @(posedge clk_i);
  endtask

  task automatic report_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
    errors++;
    if (reports < MAX_REPORTS) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      reports++;
    end
  endtask

  // Receiver side: random stalls, one long hold-off on request, none when quiet
  initial begin : result_drain
    @(posedge rst_ni);
    forever begin
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
        hold_request = 1'b0;
      end else if (!quiet_run && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 24)) @(posedge clk_i);
      end
    end
  end

  // Compare each result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    range_result_t got;
    range_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.ch   = m_axis_tuser;
      got.diff = m_axis_tdata[DIFF_W-1:0];
      got.distance = m_axis_tdata[WALL_BIT-1:DIFF_W];
      got.near = m_axis_tdata[WALL_BIT];
      results_seen++;
      if (got.distance == 16'h7FFF || got.distance == 16'h8000) saturated_seen++;
      if (got.near) near_seen++;
      if (got.diff[DIFF_W-1]) negative_seen++;
      if (expected_ranges.size() == 0) begin
        errors++;
        if (reports < MAX_REPORTS) begin
          $display("%0t ns: result with nothing expected, actual 0x%0h", $time, got);
          reports++;
        end
      end else begin
        want = expected_ranges.pop_front();
        if (got.ch != want.ch) report_field("channel_out", 16'(want.ch), 16'(got.ch));
        if (got.diff != want.diff) report_field("reflect_diff", 16'(want.diff), 16'(got.diff));
        if (got.distance != want.distance) begin
          report_field("distance", want.distance, got.distance);
        end
        if (got.near != want.near) report_field("wall_near", 16'(want.near), 16'(got.near));
      end
    end
  end

  // Stimulus: reset, directed table, then random blocks per threshold setting
  initial begin : stimulus
    logic [CH_W-1:0]  ch;
    logic [ADC_W-1:0] ambient;
    logic [ADC_W-1:0] lit;
    logic [THR_W-1:0] front_set;
    logic [THR_W-1:0] side_set;
    int               pick;
    int               level;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows run against the reset thresholds
    for (int i = 0; i < NUM_ROWS; i++) begin
      offer_sample(DIRECTED_ROWS[i].ch, DIRECTED_ROWS[i].ambient, DIRECTED_ROWS[i].lit,
                   DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].res);
    end
    s_axis_tvalid <= 1'b0;
    wait_for_results(SETTLE_LIMIT);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      // Pick thresholds: channel 0 and 1 zero-difference distances, extremes, then random
      case (phase)
        0: begin front_set = 8'd127; side_set = 8'd94;  end
        1: begin front_set = 8'd0;   side_set = 8'd255; end
        2: begin front_set = 8'd255; side_set = 8'd0;   end
        default: begin
          front_set = THR_W'($urandom_range(0, 255));
          side_set  = THR_W'($urandom_range(0, 255));
        end
      endcase
      write_limit(CFG_FRONT_THR, front_set);
      write_limit(CFG_SIDE_THR, side_set);
      // Unmapped index: the block must drop it
      write_limit(CFG_IDX_W'($urandom_range(2, 15)), THR_W'($urandom_range(0, 255)));
      cfg_valid_i <= 1'b0;
      settings_run++;
      @(posedge clk_i);

      // Last block runs with no pauses on either side
      if (phase == RANDOM_PHASES - 1) quiet_run = 1'b1;

      for (int n = 0; n < SAMPLES_PER_PHASE; n++) begin
        // Back up the pipeline once while samples keep coming
        if (phase == 1 && n == 40) hold_request = 1'b1;
        ch   = CH_W'($urandom_range(0, 3));
        pick = $urandom_range(0, 15);
        ambient = ADC_W'($urandom_range(0, ADC_MAX));
        if (pick < 10) begin
          lit = ADC_W'($urandom_range(0, ADC_MAX));
        end else if (pick < 13) begin
          // small difference keeps the distance near the thresholds
          level = int'(ambient) + int'($urandom_range(0, 600)) - 300;
          if (level < 0) level = 0;
          if (level > ADC_MAX) level = ADC_MAX;
          lit = ADC_W'(level);
        end else if (pick == 13) begin
          lit = ambient;
        end else begin
          ambient = $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
          lit     = $urandom_range(0, 1) ? ADC_W'(ADC_MAX) : '0;
        end
        offer_sample(ch, ambient, lit, 1'b0, '0);
      end
      s_axis_tvalid <= 1'b0;
      wait_for_results(SETTLE_LIMIT);
    end

    if (expected_ranges.size() != 0) begin
      errors += expected_ranges.size();
      $display("%0t ns: %0d expected results never arrived", $time, expected_ranges.size());
    end

    $display("Sent %0d samples over %0d threshold settings plus reset values, %0d results back",
             samples_sent, settings_run, results_seen);
    $display("Saw %0d saturated distances, %0d near-wall flags, %0d negative differences",
             saturated_seen, near_seen, negative_seen);
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Hang guard, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule

// ----- sim.f -----
design/irl_pkg.sv
design/irl_poly.sv
design/irl_finish.sv
design/ir_range_linearizer_top.sv
design/irl_checker.sv
sim/tb_ir_range_linearizer_top.sv
